### rtl/fir_convolve_correlate_core_macros.svh
// Assertion macros shared by the convolution/correlation core.
`ifndef FIR_CONVOLVE_CORRELATE_CORE_MACROS_SVH
`define FIR_CONVOLVE_CORRELATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcc assertion failed");

`endif

### rtl/fcc_pkg.sv
// Shared types and constants for the convolution/correlation core.
package fcc_pkg;

   // Width of one result (exact Q8.30 sum of products)
   localparam int RESULT_BITS = 38;

   // Request function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PRE   = 6'b000010,
      ST_RUN   = 6'b000100,
      ST_POST  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_EMIT  = 6'b100000
   } fcc_state_type;

   // Moves broadcast to every cell of the chain
   typedef struct packed {
      logic samp_shift;  // take sample from lower neighbor (new sample enters cell 0)
      logic samp_rot;    // take sample from upper neighbor, circular
      logic samp_clear;  // zero the sample line
      logic coef_rot_l;  // take coefficient from upper neighbor, circular
      logic coef_rot_r;  // take coefficient from lower neighbor, circular
   } fcc_cell_ctrl_type;

   // Accumulator control
   typedef struct packed {
      logic clear;   // start a new sum
      logic mac_en;  // head pair counts toward the sum
   } fcc_mac_ctrl_type;

endpackage

### rtl/fcc_cell.sv
// One cell of the chain: a sample slot and a coefficient slot.
module fcc_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcc_pkg::fcc_cell_ctrl_type    ctrl,
   input  logic                          coef_we,
   input  logic signed [SAMPLE_BITS-1:0] coef_wdata,
   input  logic signed [SAMPLE_BITS-1:0] samp_lower,
   input  logic signed [SAMPLE_BITS-1:0] samp_upper,
   input  logic signed [SAMPLE_BITS-1:0] coef_lower,
   input  logic signed [SAMPLE_BITS-1:0] coef_upper,
   output logic signed [SAMPLE_BITS-1:0] samp_q,
   output logic signed [SAMPLE_BITS-1:0] coef_q
);
   import fcc_pkg::*;

   logic signed [SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic signed [SAMPLE_BITS-1:0] coef_ff, coef_in;

   // Sample slot: clear, shift in, or rotate toward the head
   always_comb begin
      samp_in = samp_ff;
      if (ctrl.samp_clear) begin
         samp_in = '0;
      end else if (ctrl.samp_shift) begin
         samp_in = samp_lower;
      end else if (ctrl.samp_rot) begin
         samp_in = samp_upper;
      end
   end

   // Coefficient slot: load, or rotate either way
   always_comb begin
      coef_in = coef_ff;
      if (coef_we) begin
         coef_in = coef_wdata;
      end else if (ctrl.coef_rot_l) begin
         coef_in = coef_upper;
      end else if (ctrl.coef_rot_r) begin
         coef_in = coef_lower;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_ff <= '0;
      end else begin
         samp_ff <= samp_in;
      end
   end

   // Coefficients are undefined until loaded
   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign samp_q = samp_ff;
   assign coef_q = coef_ff;

endmodule

### rtl/fcc_mac.sv
// Multiply-accumulate unit at the head of the chain.
module fcc_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fcc_pkg::fcc_mac_ctrl_type          ctrl,
   input  logic signed [SAMPLE_BITS-1:0]      coef,
   input  logic signed [SAMPLE_BITS-1:0]      samp,
   output logic [fcc_pkg::RESULT_BITS-1:0]    acc
);
   import fcc_pkg::*;

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int EW = (PW > RESULT_BITS) ? PW : RESULT_BITS;

   logic signed [PW-1:0]    prod_in, prod_ff;
   logic signed [EW-1:0]    prod_ext;
   logic                    prod_en_ff;
   logic [RESULT_BITS-1:0]  acc_ff, acc_in;

   // Product stage
   assign prod_in  = coef * samp;
   assign prod_ext = EW'(prod_ff);

   // Accumulate stage, wraps at the result width
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_en_ff) begin
         acc_in = acc_ff + prod_ext[RESULT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_en_ff <= 1'b0;
      end else begin
         prod_en_ff <= ctrl.mac_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/fir_convolve_correlate_core.sv
// Top level: streaming linear convolution / cross-correlation over a cell chain.
//
// Usage: req_ carries one request per accepted beat (req_valid high, req_stall low).
// req_func 0 loads the next coefficient (req_is_last closes the load and fixes the
// tap count); req_func 1 feeds a sample and gives one result on rsp_. After a
// sample marked req_is_last the block also returns tap_count-1 tail results and
// flags the final one with rsp_last_out. csr_ writes the correlate mode bit;
// csr_ready is always high.
// A coefficient load is written straight into its cell. Each result takes one full
// circular pass of the chain. In correlation mode with two or more taps the
// coefficient chain is first turned to its last tap and turned back after. The single
// head multiplier sees one sample/coefficient pair per cycle.
// The result then waits in an output register; the next request is accepted
// while it waits. If rsp_stall holds a result when the next one is done, the
// sequencer waits and req_stall stays high.
// Reset: synchronous; clears sample line, tap count, load pointer and mode.
// Coefficients are undefined until loaded.
`include "fir_convolve_correlate_core_macros.svh"

module fir_convolve_correlate_core #(
   parameter int MAX_TAPS    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic signed [SAMPLE_BITS-1:0]         req_value,
   input  logic                                  req_is_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fcc_pkg::RESULT_BITS-1:0] rsp_result,
   output logic                                  rsp_last_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_correlate_mode
);
   import fcc_pkg::*;

   localparam int IW = $clog2(MAX_TAPS);
   localparam int TW = $clog2(MAX_TAPS + 1);

   fcc_state_type           state_ff, state_in;
   logic [IW-1:0]           cnt_ff, cnt_in;
   logic [IW-1:0]           tail_ff, tail_in;
   logic                    seq_last_ff, seq_last_in;
   logic [TW-1:0]           tap_count_ff, tap_count_in;
   logic [TW-1:0]           load_ptr_ff, load_ptr_in;
   logic                    corr_ff, corr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0]  rsp_result_ff, rsp_result_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_accept, load_accept, samp_accept, out_free;
   logic                    multi_tap, run_last;
   logic [TW-1:0]           tap_m1, ptr_step;
   logic signed [SAMPLE_BITS-1:0] shin_value;
   fcc_cell_ctrl_type       cell_ctrl;
   fcc_mac_ctrl_type        mac_ctrl;
   logic [MAX_TAPS-1:0]     coef_we;
   logic [RESULT_BITS-1:0]  acc;

   logic signed [SAMPLE_BITS-1:0] samp_q  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] coef_q  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] samp_lo [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] samp_hi [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] coef_lo [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] coef_hi [MAX_TAPS];

   // Handshakes
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign load_accept = req_accept && (req_func == FUNC_LOAD);
   assign samp_accept = req_accept && (req_func == FUNC_SAMPLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_ready   = 1'b1;

   // Pass bookkeeping
   assign multi_tap = (tap_count_ff > TW'(1));
   assign tap_m1    = tap_count_ff - TW'(1);
   assign run_last  = (cnt_ff == IW'(MAX_TAPS - 1));
   assign ptr_step  = (load_ptr_ff < TW'(MAX_TAPS)) ? (load_ptr_ff + TW'(1)) : load_ptr_ff;

   // Mode register
   assign corr_in = csr_valid ? csr_correlate_mode : corr_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      tail_in       = tail_ff;
      seq_last_in   = seq_last_ff;
      tap_count_in  = tap_count_ff;
      load_ptr_in   = load_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_last_in   = rsp_last_ff;
      shin_value    = req_value;
      cell_ctrl     = '0;
      mac_ctrl.clear = 1'b0;
      // Only the first tap_count head pairs count toward the sum
      mac_ctrl.mac_en = (state_ff == ST_RUN) && (TW'(cnt_ff) < tap_count_ff);

      case (state_ff)
         ST_IDLE: begin
            if (load_accept) begin
               load_ptr_in  = req_is_last ? '0 : ptr_step;
               tap_count_in = req_is_last ? ptr_step : tap_count_ff;
            end
            if (samp_accept) begin
               cell_ctrl.samp_shift = 1'b1;
               mac_ctrl.clear       = 1'b1;
               seq_last_in          = req_is_last;
               tail_in              = (req_is_last && multi_tap) ? IW'(tap_m1) : '0;
               if (corr_ff && multi_tap) begin
                  state_in = ST_PRE;
                  cnt_in   = IW'(tap_m1);
               end else begin
                  state_in = ST_RUN;
                  cnt_in   = '0;
               end
            end
         end

         // Turn the coefficient chain so the last tap sits at the head
         ST_PRE: begin
            cell_ctrl.coef_rot_l = 1'b1;
            if (cnt_ff == IW'(1)) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff - IW'(1);
            end
         end

         // One full turn of both chains past the head multiplier
         ST_RUN: begin
            cell_ctrl.samp_rot   = 1'b1;
            cell_ctrl.coef_rot_l = !corr_ff;
            cell_ctrl.coef_rot_r = corr_ff;
            if (run_last) begin
               if (corr_ff && multi_tap) begin
                  state_in = ST_POST;
                  cnt_in   = IW'(tap_m1);
               end else begin
                  state_in = ST_DRAIN;
               end
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end

         // Undo the pre-turn of the coefficient chain
         ST_POST: begin
            cell_ctrl.coef_rot_r = 1'b1;
            if (cnt_ff == IW'(1)) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - IW'(1);
            end
         end

         // Last product lands in the accumulator
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc;
               rsp_last_in   = seq_last_ff && (tail_ff == '0);
               if (tail_ff != '0) begin
                  // Tail output: feed a zero and run another pass
                  tail_in              = tail_ff - IW'(1);
                  shin_value           = '0;
                  cell_ctrl.samp_shift = 1'b1;
                  mac_ctrl.clear       = 1'b1;
                  if (corr_ff && multi_tap) begin
                     state_in = ST_PRE;
                     cnt_in   = IW'(tap_m1);
                  end else begin
                     state_in = ST_RUN;
                     cnt_in   = '0;
                  end
               end else begin
                  cell_ctrl.samp_clear = seq_last_ff;
                  state_in             = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         seq_last_ff  <= 1'b0;
         tap_count_ff <= '0;
         load_ptr_ff  <= '0;
         corr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tail_ff      <= tail_in;
         seq_last_ff  <= seq_last_in;
         tap_count_ff <= tap_count_in;
         load_ptr_ff  <= load_ptr_in;
         corr_ff      <= corr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result   = rsp_result_ff;
   assign rsp_last_out = rsp_last_ff;

   // Cell chain with circular neighbor links
   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      assign coef_we[i] = load_accept && (load_ptr_ff == TW'(i));

      if (i == 0) begin : g_first
         assign samp_lo[i] = shin_value;
         assign coef_lo[i] = coef_q[MAX_TAPS-1];
      end else begin : g_mid_lo
         assign samp_lo[i] = samp_q[i-1];
         assign coef_lo[i] = coef_q[i-1];
      end

      if (i == MAX_TAPS - 1) begin : g_last
         assign samp_hi[i] = samp_q[0];
         assign coef_hi[i] = coef_q[0];
      end else begin : g_mid_hi
         assign samp_hi[i] = samp_q[i+1];
         assign coef_hi[i] = coef_q[i+1];
      end

      fcc_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .coef_we    (coef_we[i]),
         .coef_wdata (req_value),
         .samp_lower (samp_lo[i]),
         .samp_upper (samp_hi[i]),
         .coef_lower (coef_lo[i]),
         .coef_upper (coef_hi[i]),
         .samp_q     (samp_q[i]),
         .coef_q     (coef_q[i])
      );
   end

   // Head multiplier and accumulator
   fcc_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (coef_q[0]),
      .samp  (samp_q[0]),
      .acc   (acc)
   );

   // Checks
   `FCC_ASSERT_NEXT(a_hold_result, clock, reset, state_ff == ST_EMIT && rsp_valid_ff && rsp_stall, state_ff == ST_EMIT)
   `FCC_ASSERT_IMPL(a_tail_in_last, clock, reset, tail_ff != '0, seq_last_ff)
   `FCC_ASSERT_NEXT(a_run_exit, clock, reset, state_ff == ST_RUN && run_last, state_ff == ST_POST || state_ff == ST_DRAIN)

endmodule

### tb/sv/tb_fir_convolve_correlate_core.sv
// Self-checking testbench for the streaming FIR convolution/correlation core.
`timescale 1ns / 1ps

module tb_fir_convolve_correlate_core;
   import fcc_pkg::*;

   localparam int MAX_TAPS       = 64;
   localparam int SAMPLE_BITS    = 16;
   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int MAX_GAP        = 11;
   localparam int MAX_REPORTS    = 10;
   localparam int TARGET_REQUESTS = 500;
   // settle margin covers the longest single result pass (correlation, full chain)
   localparam int SETTLE_CYCLES  = 3 * MAX_TAPS + 16;
   localparam int STALL_LIMIT    = 4000;

   localparam logic MODE_CONVOLVE  = 1'b0;
   localparam logic MODE_CORRELATE = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_t;
   typedef logic signed [RESULT_BITS-1:0] sum_t;

   localparam sample_t SAMPLE_MIN = 16'sh8000;
   localparam sample_t SAMPLE_MAX = 16'sh7fff;

   typedef struct packed {
      sum_t value;
      logic last_flag;
   } conv_out_t;

   // Tracks filter state and holds the sums still owed by the block
   class conv_scoreboard;
      sample_t     coef_mem [MAX_TAPS];
      sample_t     sample_line [MAX_TAPS];  // entry 0 is the newest sample
      int unsigned tap_count;
      int unsigned load_ptr;
      logic        mode;
      conv_out_t   expected_outs [$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned deepest_taps;

      function new();
         tap_count       = 0;
         load_ptr        = 0;
         mode            = MODE_CONVOLVE;
         mismatches      = 0;
         results_checked = 0;
         deepest_taps    = 0;
         foreach (coef_mem[i]) coef_mem[i] = '0;
         foreach (sample_line[i]) sample_line[i] = '0;
      endfunction

      function int unsigned pending();
         return expected_outs.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
      endfunction

      function void shift_in(sample_t v);
         for (int i = MAX_TAPS - 1; i > 0; i--) sample_line[i] = sample_line[i-1];
         sample_line[0] = v;
      endfunction

      // Exact sum of products over the loaded taps; correlation reads taps reversed
      function sum_t tap_products_sum();
         longint      acc;
         int unsigned ci;
         acc = 0;
         for (int unsigned j = 0; j < tap_count; j++) begin
            ci = (mode == MODE_CORRELATE) ? tap_count - 1 - j : j;
            acc += longint'(coef_mem[ci]) * longint'(sample_line[j]);
         end
         return sum_t'(acc);
      endfunction

      function void note_request(logic func, sample_t value, logic is_last);
         int unsigned n_outs;
         conv_out_t   item;
         if (func == FUNC_LOAD) begin
            // elements past the end of the store are dropped
            if (load_ptr < MAX_TAPS) begin
               coef_mem[load_ptr] = value;
               load_ptr++;
            end
            if (is_last) begin
               tap_count = load_ptr;
               load_ptr  = 0;
               if (tap_count > deepest_taps) deepest_taps = tap_count;
            end
         end else begin
            // the closing sample also flushes the tail with zeros
            n_outs = (is_last && tap_count > 1) ? tap_count : 1;
            shift_in(value);
            for (int unsigned k = 0; k < n_outs; k++) begin
               if (k != 0) shift_in('0);
               item.value     = tap_products_sum();
               item.last_flag = is_last && (k == n_outs - 1);
               expected_outs.push_back(item);
            end
            if (is_last) foreach (sample_line[i]) sample_line[i] = '0;
         end
      endfunction

      function void check_output(sum_t value, logic last_flag);
         conv_out_t want;
         results_checked++;
         if (expected_outs.size() == 0) begin
            flag($sformatf("result %0d arrived with nothing expected: sum %0d last %0b",
                           results_checked, value, last_flag));
            return;
         end
         want = expected_outs.pop_front();
         if (value !== want.value)
            flag($sformatf("result %0d: sum expected %0d, got %0d",
                           results_checked, want.value, value));
         if (last_flag !== want.last_flag)
            flag($sformatf("result %0d: last_out expected %0b, got %0b",
                           results_checked, want.last_flag, last_flag));
      endfunction
   endclass

   logic    clock              = 1'b0;
   logic    reset              = 1'b1;
   logic    req_valid          = 1'b0;
   logic    req_stall;
   logic    req_func           = FUNC_LOAD;
   sample_t req_value          = '0;
   logic    req_is_last        = 1'b0;
   logic    rsp_valid;
   logic    rsp_stall          = 1'b0;
   sum_t    rsp_result;
   logic    rsp_last_out;
   logic    csr_valid          = 1'b0;
   logic    csr_ready;
   logic    csr_correlate_mode = MODE_CONVOLVE;

   conv_scoreboard board = new();

   bit          no_idle     = 1'b0;
   int unsigned sent_count  = 0;
   int unsigned loads_seen  = 0;
   int unsigned samples_seen = 0;
   int unsigned mode_writes = 0;
   int unsigned idle_cycles = 0;

   fir_convolve_correlate_core #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_value          (req_value),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_last_out       (rsp_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_correlate_mode (csr_correlate_mode)
   );

   always #CLK_HALF clock = ~clock;

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Random value with a bias toward the extremes
   function automatic sample_t rand_value();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         default: return sample_t'($urandom);
      endcase
   endfunction

   // Present one request after a random gap; returns at the accepting edge
   task automatic send_request(logic func, sample_t value, logic is_last);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_value   <= value;
      req_is_last <= is_last;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Hold off until every owed result is back, then let a load finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic mode_sel);
      csr_valid          <= 1'b1;
      csr_correlate_mode <= mode_sel;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // An optional filter load followed by a sample run, with occasional stray or broken items
   task automatic run_sequence(int unsigned taps);
      int unsigned n_samples;
      logic        close_load;
      close_load = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 4) != 0) begin
         for (int unsigned i = 0; i < taps; i++) begin
            if ($urandom_range(0, 15) == 0) send_request(FUNC_SAMPLE, rand_value(), 1'b0);
            send_request(FUNC_LOAD, rand_value(), close_load && (i == taps - 1));
         end
      end
      n_samples = $urandom_range(1, 12);
      for (int unsigned i = 0; i < n_samples; i++)
         send_request(FUNC_SAMPLE, rand_value(),
                      (i == n_samples - 1) && ($urandom_range(0, 9) != 0));
   endtask

   // Result side: per result, stall for a drawn number of cycles
   initial begin : rsp_side
      int unsigned hold;
      wait (reset == 1'b0);
      forever begin
         hold = draw_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 1) != 0) begin
               do @(posedge clock); while (!rsp_valid);
               repeat (hold - 1) @(posedge clock);
            end else begin
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Handshake monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin : monitor
      logic took_req, took_rsp, took_csr;
      if (!reset) begin
         took_rsp = rsp_valid && !rsp_stall;
         took_req = req_valid && !req_stall;
         took_csr = csr_valid && csr_ready;
         if (took_rsp) board.check_output(rsp_result, rsp_last_out);
         if (took_req) begin
            board.note_request(req_func, req_value, req_is_last);
            if (req_func == FUNC_LOAD) loads_seen++;
            else samples_seen++;
         end
         if (took_csr) begin
            board.mode = csr_correlate_mode;
            mode_writes++;
         end
         if (took_req || took_rsp || took_csr) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("ERROR: nothing accepted for %0d cycles, %0d results still owed",
               STALL_LIMIT, board.pending());
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase, seq, n_seq, taps;
      logic        mode_sel;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // no taps loaded yet: every sample gives zero, closing sample has no tail
      send_request(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      send_request(FUNC_SAMPLE, SAMPLE_MIN, 1'b1);
      // single tap at the negative extreme
      send_request(FUNC_LOAD, SAMPLE_MIN, 1'b1);
      send_request(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      send_request(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      send_request(FUNC_SAMPLE, sample_t'(-1), 1'b1);
      // three taps, two tail results
      send_request(FUNC_LOAD, SAMPLE_MAX, 1'b0);
      send_request(FUNC_LOAD, SAMPLE_MIN, 1'b0);
      send_request(FUNC_LOAD, sample_t'(1), 1'b1);
      send_request(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      send_request(FUNC_SAMPLE, SAMPLE_MAX, 1'b1);
      // sample arriving while a new load is half written
      send_request(FUNC_LOAD, sample_t'(-1), 1'b0);
      send_request(FUNC_SAMPLE, sample_t'(16'h1234), 1'b0);
      send_request(FUNC_LOAD, sample_t'(16'h7ffe), 1'b1);
      send_request(FUNC_SAMPLE, sample_t'(-2), 1'b1);
      // same shape in correlation mode
      wait_idle();
      write_mode(MODE_CORRELATE);
      send_request(FUNC_LOAD, SAMPLE_MAX, 1'b0);
      send_request(FUNC_LOAD, '0, 1'b0);
      send_request(FUNC_LOAD, SAMPLE_MIN, 1'b1);
      send_request(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      send_request(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      send_request(FUNC_SAMPLE, sample_t'(1), 1'b1);

      // random phases; the mode changes only with the block drained
      phase = 0;
      while (sent_count < TARGET_REQUESTS) begin
         wait_idle();
         mode_sel = (phase < 2) ? logic'(phase % 2) : logic'($urandom_range(0, 1));
         write_mode(mode_sel);
         no_idle = ($urandom_range(0, 3) == 0);
         n_seq = $urandom_range(2, 5);
         for (seq = 0; seq < n_seq; seq++) begin
            // first phases open with an overlong load; full-depth filters stay rare
            if (seq == 0 && phase < 2) taps = MAX_TAPS + 2;
            else if ($urandom_range(0, 39) == 0) taps = $urandom_range(MAX_TAPS - 3, MAX_TAPS);
            else taps = $urandom_range(1, 8);
            run_sequence(taps);
         end
         phase++;
      end
      no_idle = 1'b0;
      wait_idle();

      $display("Run covered %0d requests (%0d coefficient loads, %0d samples), %0d mode writes.",
               sent_count, loads_seen, samples_seen, mode_writes);
      $display("%0d results checked, longest filter %0d taps, %0d mismatches.",
               board.results_checked, board.deepest_taps, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/fcc_pkg.sv
rtl/fcc_cell.sv
rtl/fcc_mac.sv
rtl/fir_convolve_correlate_core.sv
tb/sv/tb_fir_convolve_correlate_core.sv
